// File: sv/rws_pkg.sv
package rws_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_DRAW  = 2'd2;

    localparam logic [2:0] STS_CLEARED  = 3'd0;
    localparam logic [2:0] STS_LOADED   = 3'd1;
    localparam logic [2:0] STS_SELECTED = 3'd2;
    localparam logic [2:0] STS_FULL     = 3'd3;
    localparam logic [2:0] STS_EMPTY    = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] fitness;
        logic [31:0] random_draw;
    } in_item_t;

    typedef struct packed {
        logic [7:0] selected_index;
        logic [2:0] status;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_READ,
        S_CMP,
        S_FIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic mul_lo;
        logic mul_hi;
        logic rd;
        logic cmp;
        logic fin;
    } rws_cmd_t;

    typedef struct packed {
        logic draw_go;
        logic search_done;
    } rws_stat_t;

endpackage

// File: sv/rws_datapath.sv
module rws_datapath
    import rws_pkg::*;
#(
    parameter int MAX_POPULATION = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  rws_cmd_t  cmd,
    output rws_stat_t stat,
    output out_item_t out_item
);

    localparam int IDX_W = $clog2(MAX_POPULATION);
    localparam int CNT_W = IDX_W + 1;
    localparam int SUM_W = 32 + IDX_W;

    logic [SUM_W-1:0] mem [MAX_POPULATION];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] total_reg, total_next;
    logic [31:0]      u_reg;
    logic [63:0]      prod_reg;
    logic [SUM_W-1:0] t_reg;
    logic [IDX_W-1:0] lo_reg;
    logic [IDX_W-1:0] hi_reg;
    logic [IDX_W-1:0] mid_reg;
    logic [SUM_W-1:0] rdata_reg;
    out_item_t        out_item_reg, out_item_next;

    logic             out_wr;
    logic             mem_wr;
    logic             empty;
    logic             full;
    logic [IDX_W:0]   mid_sum;
    logic [IDX_W-1:0] mid;
    logic [SUM_W-1:0] hi_prod;

    assign empty   = (count_reg == '0) || (total_reg == '0);
    assign full    = count_reg >= CNT_W'(MAX_POPULATION);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[IDX_W:1];
    assign hi_prod = SUM_W'(u_reg) * SUM_W'(total_reg[SUM_W-1:32]);

    assign stat.draw_go     = (in_item.operation == OP_DRAW) && !empty;
    assign stat.search_done = lo_reg >= hi_reg;
    assign out_item         = out_item_reg;

    always_comb
    begin
        count_next    = count_reg;
        total_next    = total_reg;
        out_item_next = out_item_reg;
        out_wr        = 1'b0;
        mem_wr        = 1'b0;
        if (cmd.accept)
        begin
            out_item_next.selected_index = '0;
            case (in_item.operation)
                OP_CLEAR:
                begin
                    count_next           = '0;
                    total_next           = '0;
                    out_item_next.status = STS_CLEARED;
                    out_wr               = 1'b1;
                end
                OP_LOAD:
                begin
                    out_wr = 1'b1;
                    if (full)
                    begin
                        out_item_next.status = STS_FULL;
                    end
                    else
                    begin
                        total_next                   = total_reg + SUM_W'(in_item.fitness);
                        count_next                   = count_reg + CNT_W'(1);
                        mem_wr                       = 1'b1;
                        out_item_next.selected_index = 8'(count_reg);
                        out_item_next.status         = STS_LOADED;
                    end
                end
                OP_DRAW:
                begin
                    out_item_next.status = STS_EMPTY;
                    out_wr               = empty;
                end
                default:
                begin
                    out_item_next.status = STS_EMPTY;
                    out_wr               = 1'b1;
                end
            endcase
        end
        else if (cmd.fin)
        begin
            out_item_next.selected_index = 8'(lo_reg);
            out_item_next.status         = STS_SELECTED;
            out_wr                       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[count_reg[IDX_W-1:0]] <= total_next;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[mid];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_wr)
        begin
            out_item_reg <= out_item_next;
        end
        if (cmd.accept)
        begin
            u_reg <= in_item.random_draw;
        end
        if (cmd.mul_lo)
        begin
            prod_reg <= 64'(u_reg) * 64'(total_reg[31:0]);
        end
        if (cmd.mul_hi)
        begin
            t_reg  <= hi_prod + SUM_W'(prod_reg[63:32]);
            lo_reg <= '0;
            hi_reg <= IDX_W'(count_reg - CNT_W'(1));
        end
        if (cmd.rd)
        begin
            mid_reg <= mid;
        end
        if (cmd.cmp)
        begin
            if (rdata_reg > t_reg)
            begin
                hi_reg <= mid_reg;
            end
            else
            begin
                lo_reg <= IDX_W'(mid_reg + IDX_W'(1));
            end
        end
    end

endmodule

// File: sv/rws_ctrl.sv
module rws_ctrl
    import rws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  rws_stat_t stat,
    output rws_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = accept;
                if (accept)
                begin
                    if (stat.draw_go)
                    begin
                        state_next = S_MUL_LO;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                if (stat.search_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_READ;
            end
            S_FIN:
            begin
                cmd.fin        = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // result slot is always free when a draw completes
    a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> !out_valid_reg)
        else $error("draw completed with result slot occupied");

    a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> out_valid_reg)
        else $error("draw result not presented");

    a_draw_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stat.draw_go) |=> (state_reg == S_MUL_LO) && !out_valid_reg)
        else $error("draw did not start search");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> !out_valid_reg)
        else $error("result pending during search");
`endif

endmodule

// File: sv/roulette_wheel_selector_unit.sv
// Channel   Direction  Signals                       Payload
// in        input      in_valid, in_ready, in_item   operation, fitness, random_draw
// out       output     out_valid, out_ready, out_item selected_index, status
//
// Clear, load, unused opcodes and every non-searching draw: result registered, valid in the cycle after acceptance.
// Searching draw: two multiply steps after acceptance, then up to ceil(log2(entries))
// search steps (one table read and one compare per step), a final check and a
// result step.
// One transaction in flight; in_ready needs the result register free or draining.
// rst_n asynchronous, active low; table contents are undefined until loaded.
module roulette_wheel_selector_unit
    import rws_pkg::*;
#(
    parameter int MAX_POPULATION = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    rws_cmd_t  cmd;
    rws_stat_t stat;

    rws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rws_datapath #(
        .MAX_POPULATION (MAX_POPULATION)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (out_item)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench
    import rws_pkg::*;
;

    localparam int          POP       = 256;
    localparam int          ITEMS     = 1800;
    localparam int          LIMIT     = 1000000;
    localparam int          HOLD_LEN  = 400;
    localparam int          TAIL_WAIT = 40;
    localparam logic [1:0]  OP_UNUSED = 2'd3;

    class wheel_scoreboard;
        logic [39:0]  cum_sums [POP];
        int unsigned  n_entries;
        logic [39:0]  total;
        out_item_t    pending_picks [$];
        int unsigned  n_errors;

        function new();
            n_entries = 0;
            total     = '0;
            n_errors  = 0;
        endfunction

        // predicts the outcome of one accepted transaction and queues it
        function void note_request(in_item_t req);
            out_item_t    pick;
            logic [71:0]  product;
            logic [39:0]  threshold;
            int unsigned  lo;
            int unsigned  hi;
            int unsigned  mid;
            pick.selected_index = '0;
            pick.status         = STS_EMPTY;
            case (req.operation)
                OP_CLEAR:
                begin
                    n_entries   = 0;
                    total       = '0;
                    pick.status = STS_CLEARED;
                end
                OP_LOAD:
                begin
                    if (n_entries >= POP)
                    begin
                        pick.status = STS_FULL;
                    end
                    else
                    begin
                        total               = total + {8'd0, req.fitness};
                        cum_sums[n_entries] = total;
                        pick.selected_index = n_entries[7:0];
                        pick.status         = STS_LOADED;
                        n_entries++;
                    end
                end
                OP_DRAW:
                begin
                    if (n_entries != 0 && total != '0)
                    begin
                        // u * total / 2^32, truncated
                        product   = {40'd0, req.random_draw} * {32'd0, total};
                        threshold = product[71:32];
                        lo = 0;
                        hi = n_entries - 1;
                        while (lo < hi)
                        begin
                            mid = (lo + hi) >> 1;
                            if (cum_sums[mid] > threshold)
                                hi = mid;
                            else
                                lo = mid + 1;
                        end
                        pick.selected_index = lo[7:0];
                        pick.status         = STS_SELECTED;
                    end
                end
                default:
                begin
                end
            endcase
            pending_picks = {pending_picks, pick};
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_picks.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected transaction: selected_index %0d status %0d",
                             got.selected_index, got.status);
            end
            else
            begin
                want = pending_picks.pop_front();
                if (got.selected_index !== want.selected_index || got.status !== want.status)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: selected_index exp %0d got %0d, status exp %0d got %0d",
                                 want.selected_index, got.selected_index,
                                 want.status, got.status);
                end
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    wheel_scoreboard scoreboard = new();

    int  n_sent      = 0;
    int  gap_odds    = 0;
    int  cycle_count = 0;
    bit  calm        = 1'b0;
    bit  held_off    = 1'b0;

    roulette_wheel_selector_unit #(
        .MAX_POPULATION (POP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            scoreboard.check_result(out_item);
    end

    function automatic in_item_t make_item(logic [1:0] op, logic [31:0] fit,
                                           logic [31:0] draw);
        in_item_t req;
        req.operation   = op;
        req.fitness     = fit;
        req.random_draw = draw;
        return req;
    endfunction

    function automatic logic [31:0] rand_fitness();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4: return $urandom_range(1, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_draw();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input in_item_t req);
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        scoreboard.note_request(req);
        n_sent++;
        if (n_sent >= ITEMS - 200)
            calm = 1'b1;
    endtask

    task automatic run_directed();
        send_item(make_item(OP_DRAW,   32'h1234_5678, 32'h8000_0000));
        send_item(make_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_LOAD,   32'd0,         32'hFFFF_FFFF));
        send_item(make_item(OP_DRAW,   32'd0,         32'hFFFF_FFFF));
        send_item(make_item(OP_LOAD,   32'hFFFF_FFFF, 32'd0));
        send_item(make_item(OP_LOAD,   32'd0,         32'd0));
        send_item(make_item(OP_LOAD,   32'd1,         32'd0));
        send_item(make_item(OP_DRAW,   32'd0,         32'd0));
        send_item(make_item(OP_DRAW,   32'd0,         32'hFFFF_FFFF));
        send_item(make_item(OP_DRAW,   32'd0,         32'h8000_0000));
        send_item(make_item(OP_DRAW,   32'd0,         32'h0000_0001));
        send_item(make_item(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_LOAD,   32'd1,         32'd0));
        send_item(make_item(OP_DRAW,   32'd0,         32'hFFFF_FFFF));
        send_item(make_item(OP_LOAD,   32'h8000_0000, 32'd0));
        send_item(make_item(OP_LOAD,   32'h7FFF_FFFF, 32'd0));
        send_item(make_item(OP_DRAW,   32'd0,         32'h7FFF_FFFF));
        send_item(make_item(OP_DRAW,   32'd0,         32'hFFFF_FFFE));
        send_item(make_item(OP_UNUSED, 32'd0,         32'd0));
        send_item(make_item(OP_CLEAR,  32'd0,         32'd0));
        send_item(make_item(OP_DRAW,   32'd0,         32'd0));
    endtask

    task automatic run_random();
        int  seq_no;
        int  n_loads;
        int  n_draws;
        int  full_runs;
        bit  zero_fits;
        seq_no    = 0;
        full_runs = 0;
        while (n_sent < ITEMS)
        begin
            seq_no++;
            gap_odds  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
            zero_fits = ($urandom_range(0, 9) == 0);
            if (seq_no % 9 == 4 && full_runs < 2)
            begin
                n_loads   = POP + $urandom_range(1, 4);
                zero_fits = 1'b0;
                full_runs++;
            end
            else
            begin
                n_loads = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 64 : 16);
            end
            if ($urandom_range(0, 5) != 0)
                send_item(make_item(OP_CLEAR, $urandom, $urandom));
            for (int i = 0; i < n_loads; i++)
            begin
                send_item(make_item(OP_LOAD, zero_fits ? 32'd0 : rand_fitness(), $urandom));
                if ($urandom_range(0, 7) == 0)
                    send_item(make_item(OP_DRAW, $urandom, rand_draw()));
            end
            n_draws = $urandom_range(1, 12);
            for (int i = 0; i < n_draws; i++)
                send_item(make_item(OP_DRAW, $urandom, rand_draw()));
            if ($urandom_range(0, 3) == 0)
                send_item(make_item(2'($urandom_range(0, 3)), $urandom, $urandom));
        end
    endtask

    // receiver: random stalls, one long hold-off to back up the input side
    initial
    begin
        int hold_cycles;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_off && n_sent >= 600)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < HOLD_LEN; hold_cycles++)
                    @(posedge clk);
            end
            else if (calm)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random();
        in_valid <= 1'b0;
        while (scoreboard.pending_picks.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (scoreboard.n_errors == 0 && scoreboard.pending_picks.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
